// ===== rtl/dlr_pkg.sv =====
// Shared types and constants for the linear resampler.
`default_nettype none
package dlr_pkg;

  localparam int SAMPLE_W = 24;
  localparam int SPACE_W  = 18;
  localparam int RATE_W   = 32;
  localparam int BAL_W    = 40;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  // item kinds
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_UPDATE = 2'd2;
  localparam logic [1:0] KIND_SPARE  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_BLOCK_IN  = 2'd0;
  localparam logic [1:0] REG_BLOCK_OUT = 2'd1;
  localparam logic [1:0] REG_CHANNELS  = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WRITE,
    S_RA, S_RB, S_RM, S_RS, S_POS, S_POSW,
    S_UD1, S_UD1W, S_UD2, S_UD2W,
    S_SP1, S_SP2, S_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic load_item;
    logic wr_exec;
    logic rd_addr_a;
    logic rd_addr_b;
    logic rd_mult;
    logic rd_store;
    logic pos_start;
    logic pos_finish;
    logic ud_start1;
    logic ud_fin1;
    logic ud_start2;
    logic ud_fin2;
    logic ud_unity;
    logic sp_mult;
    logic sp_final;
    logic emit_adv;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic last_ch;
    logic div_busy;
    logic rates_eq;
    logic emit_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/dynamic_linear_resampler_core.sv =====
// Top level of the variable-ratio linear resampler.
//
//  channel | direction | handshake           | payload
//  in      | in        | in_valid/in_ready   | kind, sample_in, source_rate, target_rate
//  out     | out       | out_valid/out_ready | sample_out, last_sample, write_space, read_space
//  cfg     | in        | cfg_wen             | cfg_index, cfg_data
//
// One item at a time; every item ends by computing the spaces and giving its
// results. A write stores its sample and gives one result, as does a status
// item; a read fetches the two frames, interpolates and stores per channel,
// waits on the serial divider for the position wrap and gives one result per
// channel; an update runs two serial divisions, or none with equal rates. After
// reset the store is swept to zero with in_ready low. A stalled output holds the item.
`default_nettype none
module dynamic_linear_resampler_core #(
  parameter int BUFFER_DEPTH = 16384,
  parameter int MAX_CHANNELS = 8,
  parameter int SPACE_FACTOR = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic signed [23:0] sample_in,
  input  wire logic [31:0] source_rate,
  input  wire logic [31:0] target_rate,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [23:0] sample_out,
  output logic             last_sample,
  output logic signed [17:0] write_space,
  output logic signed [17:0] read_space,
  input  wire logic        cfg_wen,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);
  import dlr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dlr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dlr_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .SPACE_FACTOR (SPACE_FACTOR)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .kind        (kind),
    .sample_in   (sample_in),
    .source_rate (source_rate),
    .target_rate (target_rate),
    .sample_out  (sample_out),
    .last_sample (last_sample),
    .write_space (write_space),
    .read_space  (read_space)
  );
endmodule
`default_nettype wire

// ===== rtl/dlr_div.sv =====
// Restoring divider, one quotient bit per cycle, 48-bit dividend.
`default_nettype none
module dlr_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [47:0] num,
  input  wire logic [31:0] den,
  output logic             busy,
  output logic [47:0]      quot,
  output logic [31:0]      rem
);
  logic [5:0]  cnt;
  logic [31:0] den_q;
  logic [32:0] trial;
  logic [32:0] diff;

  // shift in one dividend bit and try the subtract
  always_comb begin
    trial = {rem, quot[47]};
    diff  = trial - {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd47;
    end else if (busy) begin
      if (cnt == '0) busy <= 1'b0;
      cnt <= cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      if (!diff[32]) begin
        rem  <= diff[31:0];
        quot <= {quot[46:0], 1'b1};
      end else begin
        rem  <= trial[31:0];
        quot <= {quot[46:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/dlr_ctrl.sv =====
// Sequencing state machine for the resampler.
`default_nettype none
module dlr_ctrl (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire dlr_pkg::sts_t sts,
  output dlr_pkg::cmd_t    cmd
);
  import dlr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (sts.clr_done) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          unique case (kind)
            KIND_WRITE:  state_next = S_WRITE;
            KIND_READ:   state_next = S_RA;
            KIND_UPDATE: state_next = S_UD1;
            default:     state_next = S_SP1;
          endcase
        end
      end
      S_WRITE: state_next = S_SP1;
      S_RA:    state_next = S_RB;
      S_RB:    state_next = S_RM;
      S_RM:    state_next = S_RS;
      S_RS:    state_next = sts.last_ch ? S_POS : S_RA;
      S_POS:   state_next = S_POSW;
      S_POSW:  if (!sts.div_busy) state_next = S_SP1;
      S_UD1:   state_next = sts.rates_eq ? S_SP1 : S_UD1W;
      S_UD1W:  if (!sts.div_busy) state_next = S_UD2;
      S_UD2:   state_next = S_UD2W;
      S_UD2W:  if (!sts.div_busy) state_next = S_SP1;
      S_SP1:   state_next = S_SP2;
      S_SP2:   state_next = S_EMIT;
      S_EMIT:  if (out_ready && sts.emit_last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      S_WRITE: cmd.wr_exec   = 1'b1;
      S_RA:    cmd.rd_addr_a = 1'b1;
      S_RB:    cmd.rd_addr_b = 1'b1;
      S_RM:    cmd.rd_mult   = 1'b1;
      S_RS:    cmd.rd_store  = 1'b1;
      S_POS:   cmd.pos_start = 1'b1;
      S_POSW:  cmd.pos_finish = !sts.div_busy;
      S_UD1: begin
        cmd.ud_unity  = sts.rates_eq;
        cmd.ud_start1 = !sts.rates_eq;
      end
      S_UD1W:  cmd.ud_fin1   = !sts.div_busy;
      S_UD2:   cmd.ud_start2 = 1'b1;
      S_UD2W:  cmd.ud_fin2   = !sts.div_busy;
      S_SP1:   cmd.sp_mult   = 1'b1;
      S_SP2:   cmd.sp_final  = 1'b1;
      S_EMIT: begin
        out_valid    = 1'b1;
        cmd.emit_adv = out_ready;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/dlr_dp.sv =====
// Datapath: sample store, configuration, position, balance and spaces.
`default_nettype none
module dlr_dp #(
  parameter int BUFFER_DEPTH = 16384,
  parameter int MAX_CHANNELS = 8,
  parameter int SPACE_FACTOR = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dlr_pkg::cmd_t cmd,
  output dlr_pkg::sts_t    sts,
  input  wire logic        cfg_wen,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data,
  input  wire logic [1:0]  kind,
  input  wire logic signed [23:0] sample_in,
  input  wire logic [31:0] source_rate,
  input  wire logic [31:0] target_rate,
  output logic signed [23:0] sample_out,
  output logic             last_sample,
  output logic signed [17:0] write_space,
  output logic signed [17:0] read_space
);
  import dlr_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int FW = AW + 1;
  localparam int CW = $clog2(MAX_CHANNELS + 1);
  localparam int JW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int PW = FW + 16;
  localparam int SW = ((PW > 32) ? PW : 32) + 1;
  localparam int XW = (FW > 12) ? FW : 12;
  localparam logic signed [41:0] BAL_HI = 42'sd549755813887;
  localparam logic signed [41:0] BAL_LO = -42'sd549755813888;

  // frames available per channel count
  function automatic logic [FW-1:0] cap_of(input logic [4:0] c);
    logic [FW-1:0] r;
    unique case (c)
      5'd2:    r = FW'(BUFFER_DEPTH / 2);
      5'd3:    r = FW'(BUFFER_DEPTH / 3);
      5'd4:    r = FW'(BUFFER_DEPTH / 4);
      5'd5:    r = FW'(BUFFER_DEPTH / 5);
      5'd6:    r = FW'(BUFFER_DEPTH / 6);
      5'd7:    r = FW'(BUFFER_DEPTH / 7);
      5'd8:    r = FW'(BUFFER_DEPTH / 8);
      5'd9:    r = FW'(BUFFER_DEPTH / 9);
      5'd10:   r = FW'(BUFFER_DEPTH / 10);
      5'd11:   r = FW'(BUFFER_DEPTH / 11);
      5'd12:   r = FW'(BUFFER_DEPTH / 12);
      5'd13:   r = FW'(BUFFER_DEPTH / 13);
      5'd14:   r = FW'(BUFFER_DEPTH / 14);
      5'd15:   r = FW'(BUFFER_DEPTH / 15);
      5'd16:   r = FW'(BUFFER_DEPTH / 16);
      default: r = FW'(BUFFER_DEPTH);
    endcase
    return r;
  endfunction

  // clamp a sign and magnitude to the 18-bit space range
  function automatic logic signed [17:0] sat18(input logic neg, input logic [47:0] mag);
    logic signed [17:0] r;
    if (!neg) r = (mag > 48'd131071) ? 18'sd131071 : $signed(mag[17:0]);
    else      r = (mag > 48'd131072) ? -18'sd131072 : -$signed(mag[17:0]);
    return r;
  endfunction

  // configuration and latched item
  logic [9:0] blk_in, blk_out;
  logic [3:0] chan_reg;
  logic [1:0] kind_q;
  logic [23:0] samp_q;
  logic [31:0] src_q, dst_q;

  // state
  logic [23:0] mem [BUFFER_DEPTH];
  logic [23:0] rdata;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] wi;
  logic [PW-1:0] pos;
  logic [15:0]   pos_lo;
  logic signed [BAL_W-1:0] bal;
  logic [31:0] ratio, incr;
  logic [JW-1:0] j, k;
  logic [23:0] a_q;
  logic signed [41:0] prod;
  logic [23:0] vals [MAX_CHANNELS];
  logic [55:0] p1, p2;
  logic neg_q;

  // derived geometry
  logic [4:0]  c5;
  logic [CW-1:0] ch_eff;
  logic [9:0]  bmax;
  logic [11:0] fsize;
  logic [FW-1:0] cap, frames;
  logic [FW+CW-1:0] len_full;
  logic [FW-1:0] len;

  always_comb begin
    c5 = {1'b0, chan_reg};
    if (c5 == 5'd0) c5 = 5'd1;
    if (c5 > 5'(MAX_CHANNELS)) c5 = 5'(MAX_CHANNELS);
    ch_eff = c5[CW-1:0];
    bmax = (blk_in > blk_out) ? blk_in : blk_out;
    if (bmax == 10'd0) bmax = 10'd1;
    fsize = 12'(bmax) * 12'(SPACE_FACTOR);
    cap = cap_of(c5);
    frames = (XW'(fsize) > XW'(cap)) ? cap : FW'(fsize);
    len_full = frames * ch_eff;
    len = len_full[FW-1:0];
  end

  // write address
  logic [FW-1:0] wi_eff, wi_inc;
  always_comb begin
    wi_eff = ({1'b0, wi} >= len) ? '0 : {1'b0, wi};
    wi_inc = wi_eff + 1'b1;
  end

  // read addresses of the two frames around the position
  logic [FW+CW:0] base, ta, tb;
  logic [AW-1:0] raddr;
  always_comb begin
    base = (FW+CW+1)'(pos[PW-1:16] * ch_eff);
    ta = base + (FW+CW+1)'(j);
    tb = base + (FW+CW+1)'(ch_eff) + (FW+CW+1)'(j);
    if (tb >= (FW+CW+1)'(len)) tb = tb - (FW+CW+1)'(len);
    raddr = cmd.rd_addr_b ? tb[AW-1:0] : ta[AW-1:0];
  end

  // shared divider
  logic [SW-1:0] psum;
  logic        div_start, div_busy;
  logic [47:0] div_num, div_quot;
  logic [31:0] div_den, div_rem, quot_sat;
  always_comb begin
    psum = SW'(pos) + SW'(incr);
    div_start = cmd.pos_start | cmd.ud_start1 | cmd.ud_start2;
    priority if (cmd.pos_start) begin
      div_num = 48'(psum[SW-1:16]);
      div_den = 32'(frames);
    end else if (cmd.ud_start1) begin
      div_num = {dst_q, 16'h0};
      div_den = src_q;
    end else begin
      div_num = {src_q, 16'h0};
      div_den = dst_q;
    end
    quot_sat = (|div_quot[47:32]) ? 32'hFFFF_FFFF : div_quot[31:0];
  end

  dlr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // balance step with saturation
  logic [36:0] chinc;
  logic signed [41:0] bdelta, bsum;
  logic signed [BAL_W-1:0] bal_next;
  always_comb begin
    chinc = 37'(ch_eff) * 37'(incr);
    bdelta = cmd.wr_exec ? 42'sd65536 : -$signed({5'b0, chinc});
    bsum = {{2{bal[BAL_W-1]}}, bal} + bdelta;
    if (bsum > BAL_HI)      bal_next = BAL_HI[BAL_W-1:0];
    else if (bsum < BAL_LO) bal_next = BAL_LO[BAL_W-1:0];
    else                    bal_next = bsum[BAL_W-1:0];
  end

  // sample store with clearing sweep
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [23:0]   mem_wd;
  always_comb begin
    mem_we = cmd.clr_step | cmd.wr_exec;
    mem_wa = cmd.clr_step ? clr_addr : wi_eff[AW-1:0];
    mem_wd = cmd.clr_step ? 24'h0 : samp_q;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata <= mem[raddr];
  end

  // interpolation
  logic signed [24:0] diff;
  logic signed [41:0] prnd;
  always_comb begin
    diff = $signed({rdata[23], rdata}) - $signed({a_q[23], a_q});
    prnd = (prod + 42'sd32768) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_addr_b) a_q <= rdata;
    if (cmd.rd_mult)   prod <= diff * $signed({1'b0, pos[15:0]});
    if (cmd.rd_store)  vals[j] <= a_q + prnd[23:0];
    if (cmd.pos_start) pos_lo <= psum[15:0];
    if (cmd.load_item) begin
      kind_q <= kind;
      samp_q <= sample_in;
      src_q  <= source_rate;
      dst_q  <= target_rate;
    end
  end

  // space products
  logic [39:0] mag;
  logic [56:0] qsum;
  logic signed [41:0] wv;
  logic [41:0] wmag;
  always_comb begin
    mag  = bal[BAL_W-1] ? 40'(-bal) : 40'(bal);
    qsum = 57'(p1) + 57'(p2[55:16]);
    wv = $signed(42'({len, 16'h0})) - {{2{bal[BAL_W-1]}}, bal} + 42'sd32768;
    wmag = wv[41] ? 42'(-wv) : 42'(wv);
  end

  always_ff @(posedge clk) begin
    if (cmd.sp_mult) begin
      p1 <= mag * ratio[31:16];
      p2 <= mag * ratio[15:0];
      neg_q <= bal[BAL_W-1];
    end
    if (cmd.sp_final) begin
      read_space  <= sat18(neg_q, 48'(qsum[56:16]));
      write_space <= sat18(wv[41], 48'(wmag[41:16]));
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_in   <= 10'd64;
      blk_out  <= 10'd64;
      chan_reg <= 4'd2;
      clr_addr <= '0;
      wi    <= '0;
      pos   <= '0;
      bal   <= '0;
      ratio <= ONE_Q16;
      incr  <= ONE_Q16;
      j <= '0;
      k <= '0;
    end else begin
      if (cmd.clr_step) clr_addr <= clr_addr + 1'b1;
      if (cmd.load_item) begin
        j <= '0;
        k <= '0;
      end
      if (cmd.rd_store) j <= j + 1'b1;
      if (cmd.emit_adv) k <= k + 1'b1;
      if (cmd.wr_exec) wi <= (wi_inc >= len) ? '0 : wi_inc[AW-1:0];
      if (cmd.wr_exec || cmd.pos_start) bal <= bal_next;
      if (cmd.pos_finish) pos <= {div_rem[FW-1:0], pos_lo};
      if (cmd.ud_fin1) ratio <= quot_sat;
      if (cmd.ud_fin2) incr  <= quot_sat;
      if (cmd.ud_unity) begin
        ratio <= ONE_Q16;
        incr  <= ONE_Q16;
      end
      // a register write restarts the stream
      if (cfg_wen && (cfg_index == REG_BLOCK_IN || cfg_index == REG_BLOCK_OUT ||
                      cfg_index == REG_CHANNELS)) begin
        unique case (cfg_index)
          REG_BLOCK_IN:  blk_in   <= cfg_data;
          REG_BLOCK_OUT: blk_out  <= cfg_data;
          default:       chan_reg <= cfg_data[3:0];
        endcase
        wi    <= '0;
        pos   <= '0;
        bal   <= '0;
        ratio <= ONE_Q16;
        incr  <= ONE_Q16;
      end
    end
  end

  // status and result fields
  logic read_item;
  always_comb begin
    read_item     = (kind_q == KIND_READ);
    sts.clr_done  = (clr_addr == AW'(BUFFER_DEPTH - 1));
    sts.last_ch   = (CW'(j) == ch_eff - 1'b1);
    sts.div_busy  = div_busy;
    sts.rates_eq  = (src_q == dst_q);
    sts.emit_last = !read_item || (CW'(k) == ch_eff - 1'b1);
    sample_out    = read_item ? $signed(vals[k]) : 24'sd0;
    last_sample   = sts.emit_last;
  end
endmodule
`default_nettype wire
